FILE: rtl/imm_pkg.sv
package imm_pkg;

    localparam int ELEM_W  = 16;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 35;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int CADDR_W = 2;
    localparam int OUT_DW  = 48;
    localparam int OUT_PAD = OUT_DW - PROD_W - 2 * IDX_W;

    localparam logic [CADDR_W-1:0] REG_ROWS_A  = 2'd0;
    localparam logic [CADDR_W-1:0] REG_INNER_A = 2'd1;
    localparam logic [CADDR_W-1:0] REG_ROWS_B  = 2'd2;
    localparam logic [CADDR_W-1:0] REG_COLS_B  = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic [1:0] {
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MULT,
        ST_ERROR
    } state_t;

    // one multiply-accumulate step travelling down the pipeline
    typedef struct packed {
        logic valid;
        logic first;   // first term of a dot product
        logic lastk;   // final term, result leaves after it
        logic last;    // final result of the run
        logic err;     // size error marker, product forced to zero
        idx_t row;
        idx_t col;
    } tok_t;

endpackage

FILE: rtl/imm_mem.sv
module imm_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/imm_ctrl.sv
module imm_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [imm_pkg::CADDR_W-1:0]  cfg_addr,
    input  imm_pkg::dim_t                cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic                         en,
    output imm_pkg::tok_t                tok,
    output logic                         a_we,
    output logic                         b_we,
    output logic [AW-1:0]                waddr,
    output logic [AW-1:0]                a_raddr,
    output logic [AW-1:0]                b_raddr
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM);
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int PW    = 2 * NW;
    localparam int XW    = (PW > CW) ? PW : CW;

    imm_pkg::state_t state_reg, state_next;
    imm_pkg::dim_t   rows_a_reg, inner_a_reg, rows_b_reg, cols_b_reg;
    logic [CW-1:0]   cnt_reg, cnt_inc;
    logic [DW-1:0]   r_reg, c_reg, k_reg;
    logic [NW-1:0]   m, n, p, q;
    logic [PW-1:0]   mn, pq;
    logic            accepted, done_a, done_b;
    logic            k_last, c_last, r_last;

    function automatic logic [NW-1:0] clamp_dim(input imm_pkg::dim_t v);
        if (v == '0) begin
            return NW'(1);
        end else if (int'(v) > MAX_DIM) begin
            return NW'(MAX_DIM);
        end
        return NW'(v);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg  <= imm_pkg::dim_t'(1);
            inner_a_reg <= imm_pkg::dim_t'(1);
            rows_b_reg  <= imm_pkg::dim_t'(1);
            cols_b_reg  <= imm_pkg::dim_t'(1);
        end else if (cfg_valid) begin
            case (cfg_addr)
                imm_pkg::REG_ROWS_A:  rows_a_reg  <= cfg_data;
                imm_pkg::REG_INNER_A: inner_a_reg <= cfg_data;
                imm_pkg::REG_ROWS_B:  rows_b_reg  <= cfg_data;
                imm_pkg::REG_COLS_B:  cols_b_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m  = clamp_dim(rows_a_reg);
    assign n  = clamp_dim(inner_a_reg);
    assign p  = clamp_dim(rows_b_reg);
    assign q  = clamp_dim(cols_b_reg);
    assign mn = PW'(m) * PW'(n);
    assign pq = PW'(p) * PW'(q);

    assign cnt_inc  = cnt_reg + CW'(1);
    assign done_a   = XW'(cnt_inc) >= XW'(mn);
    assign done_b   = XW'(cnt_inc) >= XW'(pq);
    assign accepted = s_tvalid && s_tready;

    assign k_last = (NW'(k_reg) + NW'(1)) == n;
    assign c_last = (NW'(c_reg) + NW'(1)) == q;
    assign r_last = (NW'(r_reg) + NW'(1)) == m;

    assign waddr   = cnt_reg[AW-1:0];
    assign a_raddr = AW'(r_reg) * AW'(n) + AW'(k_reg);
    assign b_raddr = AW'(k_reg) * AW'(q) + AW'(c_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imm_pkg::ST_LOAD_A: begin
                if (accepted && done_a) begin
                    state_next = (n != p) ? imm_pkg::ST_ERROR : imm_pkg::ST_LOAD_B;
                end
            end
            imm_pkg::ST_LOAD_B: begin
                if (accepted && done_b) begin
                    state_next = imm_pkg::ST_MULT;
                end
            end
            imm_pkg::ST_MULT: begin
                if (en && k_last && c_last && r_last) begin
                    state_next = imm_pkg::ST_LOAD_A;
                end
            end
            imm_pkg::ST_ERROR: begin
                if (en) begin
                    state_next = imm_pkg::ST_LOAD_A;
                end
            end
            default: state_next = imm_pkg::ST_LOAD_A;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        a_we     = 1'b0;
        b_we     = 1'b0;
        tok      = '0;
        case (state_reg)
            imm_pkg::ST_LOAD_A: begin
                s_tready = 1'b1;
                a_we     = s_tvalid;
            end
            imm_pkg::ST_LOAD_B: begin
                s_tready = 1'b1;
                b_we     = s_tvalid;
            end
            imm_pkg::ST_MULT: begin
                tok.valid = 1'b1;
                tok.first = (k_reg == '0);
                tok.lastk = k_last;
                tok.last  = k_last && c_last && r_last;
                tok.row   = imm_pkg::idx_t'(r_reg);
                tok.col   = imm_pkg::idx_t'(c_reg);
            end
            imm_pkg::ST_ERROR: begin
                tok.valid = 1'b1;
                tok.first = 1'b1;
                tok.lastk = 1'b1;
                tok.last  = 1'b1;
                tok.err   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imm_pkg::ST_LOAD_A;
            cnt_reg   <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (accepted) begin
                if ((state_reg == imm_pkg::ST_LOAD_A && done_a) ||
                    (state_reg == imm_pkg::ST_LOAD_B && done_b)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_inc;
                end
            end
            // walk k fastest, then column, then row; all wrap to zero at the end
            if (state_reg == imm_pkg::ST_MULT && en) begin
                if (k_last) begin
                    k_reg <= '0;
                    if (c_last) begin
                        c_reg <= '0;
                        r_reg <= r_last ? '0 : r_reg + DW'(1);
                    end else begin
                        c_reg <= c_reg + DW'(1);
                    end
                end else begin
                    k_reg <= k_reg + DW'(1);
                end
            end
        end
    end

    a_idle_counters_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != imm_pkg::ST_MULT |-> (r_reg == '0 && c_reg == '0 && k_reg == '0))
        else $error("loop counters not cleared outside multiply");

    a_mult_exit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::ST_MULT && state_next != imm_pkg::ST_MULT)
            |-> (en && tok.last))
        else $error("multiply left before final step");

    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::ST_MULT || state_reg == imm_pkg::ST_ERROR)
            |-> (!a_we && !b_we && !s_tready))
        else $error("store written while results are produced");

endmodule

FILE: rtl/imm_mac.sv
module imm_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  imm_pkg::tok_t                     tok,
    input  logic [imm_pkg::ELEM_W-1:0]        a_rdata,
    input  logic [imm_pkg::ELEM_W-1:0]        b_rdata,
    output logic                              en,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [imm_pkg::OUT_DW-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    imm_pkg::tok_t                      s1_reg, s2_reg;
    logic signed [imm_pkg::MUL_W-1:0]   mul_reg, mul_next;
    logic signed [imm_pkg::PROD_W-1:0]  acc_reg, sum, mul_ext;
    logic signed [imm_pkg::ELEM_W-1:0]  a_s, b_s;
    logic                               m_tvalid_reg;
    logic [imm_pkg::PROD_W-1:0]         m_product_reg;
    imm_pkg::idx_t                      m_row_reg, m_col_reg;
    logic                               m_tlast_reg, m_tuser_reg;

    // the whole pipeline freezes while a finished result waits
    assign en = !m_tvalid_reg || m_tready;

    assign a_s      = a_rdata;
    assign b_s      = b_rdata;
    assign mul_next = a_s * b_s;
    assign mul_ext  = {{(imm_pkg::PROD_W - imm_pkg::MUL_W){mul_reg[imm_pkg::MUL_W-1]}},
                       mul_reg};
    assign sum      = s2_reg.first ? mul_ext : acc_reg + mul_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_reg       <= tok;
            s2_reg       <= s1_reg;
            m_tvalid_reg <= s2_reg.valid && s2_reg.lastk;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // drop the memory data on a size error
            mul_reg <= s1_reg.err ? '0 : mul_next;
            if (s2_reg.valid) begin
                acc_reg <= sum;
            end
            if (s2_reg.valid && s2_reg.lastk) begin
                m_product_reg <= sum;
                m_row_reg     <= s2_reg.row;
                m_col_reg     <= s2_reg.col;
                m_tlast_reg   <= s2_reg.last;
                m_tuser_reg   <= s2_reg.err;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{imm_pkg::OUT_PAD{1'b0}}, m_col_reg, m_row_reg, m_product_reg};
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_error_result_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg)
            |-> (m_tlast_reg && m_product_reg == '0 && m_row_reg == '0 && m_col_reg == '0))
        else $error("size error result carries data");

    a_result_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s2_reg.valid && s2_reg.lastk) |=> m_tvalid_reg)
        else $error("finished dot product lost");

    a_last_closes_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_reg.valid && s2_reg.last) |-> s2_reg.lastk)
        else $error("run ends inside a dot product");

endmodule

FILE: rtl/integer_matrix_multiply_top.sv
// Channel  Direction  Handshake                    Payload
// s_       in         s_tvalid / s_tready          s_tdata: element
// m_       out        m_tvalid / m_tready          m_tdata: product, row, col
//                                                  m_tlast: last, m_tuser: size_error
// cfg_     in         cfg_valid / cfg_ready        cfg_addr: register, cfg_data: value
//
// Elements of A and B load at one per cycle into two block memories.
// After B, the shared multiply-accumulate walks rows_a*cols_b*inner_a steps, one
// memory read pair per cycle unless stalled; read data, product, result are registered.
// A size error costs one pipeline slot. s_tready stays low while results are made.
// An output stall freezes the read and multiply pipeline. No clearing pass after reset.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [imm_pkg::CADDR_W-1:0]       cfg_addr,
    input  logic [imm_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [imm_pkg::ELEM_W-1:0]        s_tdata,   // [15:0] element
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [imm_pkg::OUT_DW-1:0]        m_tdata,   // [34:0] product, [37:35] row,
                                                         // [40:38] col, [47:41] zero
    output logic                              m_tlast,
    output logic                              m_tuser    // [0] size_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    imm_pkg::tok_t               tok;
    logic                        en, a_we, b_we;
    logic [AW-1:0]               waddr, a_raddr, b_raddr;
    logic [imm_pkg::ELEM_W-1:0]  a_rdata, b_rdata;

    imm_ctrl #(
        .MAX_DIM(MAX_DIM),
        .AW     (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .en       (en),
        .tok      (tok),
        .a_we     (a_we),
        .b_we     (b_we),
        .waddr    (waddr),
        .a_raddr  (a_raddr),
        .b_raddr  (b_raddr)
    );

    imm_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .W    (imm_pkg::ELEM_W)
    ) u_mem_a (
        .aclk (aclk),
        .we   (a_we),
        .waddr(waddr),
        .wdata(s_tdata),
        .re   (en),
        .raddr(a_raddr),
        .rdata(a_rdata)
    );

    imm_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .W    (imm_pkg::ELEM_W)
    ) u_mem_b (
        .aclk (aclk),
        .we   (b_we),
        .waddr(waddr),
        .wdata(s_tdata),
        .re   (en),
        .raddr(b_raddr),
        .rdata(b_rdata)
    );

    imm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok     (tok),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .en      (en),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
